/* rtl/csu_pkg.sv */
// Package for the counting semaphore unit.
// Holds command and status codes and the command queue entry type; no dependencies.
package csu_pkg;
  localparam int NumSemsDefault = 16;
  localparam int NumThreadsDefault = 32;
  localparam int CountWidthDefault = 16;

  localparam logic [1:0] CMD_OPEN = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_WAIT = 2'd2;
  localparam logic [1:0] CMD_SIGNAL = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_OPEN = 2'd1;
  localparam logic [1:0] ST_NO_SLOT = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] sem_id;
    logic [4:0] thread_id;
    logic [15:0] init_value;
  } cmd_t;
endpackage

/* rtl/csu_front.sv */
// Front part of the counting semaphore unit: a two-entry command queue.
// Depends on csu_pkg.
module csu_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  csu_pkg::cmd_t in_cmd,
  output logic cmd_valid,
  input  logic cmd_take,
  output csu_pkg::cmd_t cmd_out
);
  import csu_pkg::*;

  cmd_t entry [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;

  assign full = fill == 2'd2;
  assign cmd_valid = fill != 2'd0;
  assign cmd_out = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (cmd_take && cmd_valid) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'((push && !full) ? 1 : 0) - 2'((cmd_take && cmd_valid) ? 1 : 0);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("command queue overfilled");
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0) |-> !cmd_valid) else $error("empty queue shows a command");
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (full && !cmd_take) |=> full) else $error("full dropped without a take");
endmodule

/* rtl/csu_back.sv */
// Back part of the counting semaphore unit: slot table, wait queues and result register.
// Depends on csu_pkg.
module csu_back #(
  parameter int NUM_SEMS = csu_pkg::NumSemsDefault,
  parameter int NUM_THREADS = csu_pkg::NumThreadsDefault,
  parameter int COUNT_WIDTH = csu_pkg::CountWidthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_take,
  input  csu_pkg::cmd_t cmd_in,
  output logic empty,
  input  logic pop,
  output logic [1:0] status,
  output logic [3:0] sem_handle,
  output logic caller_blocked,
  output logic woken_valid,
  output logic [4:0] woken_thread,
  output logic last
);
  import csu_pkg::*;

  localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int LIM = (NUM_SEMS < 16) ? NUM_SEMS : 16;
  localparam int CAP = (NUM_THREADS < 32) ? NUM_THREADS : 32;
  localparam int KW = $clog2(CAP + 1);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0] state;
  cmd_t cur;
  logic [NUM_SEMS-1:0] slot_open;
  logic [NUM_SEMS-1:0] queue_nonempty;
  logic [COUNT_WIDTH-1:0] sem_count [NUM_SEMS];
  logic [4:0] queue_head [NUM_SEMS];
  logic [4:0] queue_tail [NUM_SEMS];
  logic [4:0] thread_next [32];
  logic [KW-1:0] walked;

  logic [SW-1:0] sid;
  logic in_range;
  logic is_open;
  logic [4:0] hd;
  logic hd_is_tail;
  logic [3:0] free_idx;
  logic [SW-1:0] free_sid;
  logic free_found;
  logic [COUNT_WIDTH-1:0] ival_sat;

  assign sid = SW'(cur.sem_id);
  assign in_range = 32'(cur.sem_id) < NUM_SEMS;
  assign is_open = in_range && slot_open[sid];
  assign hd = queue_head[sid];
  assign hd_is_tail = hd == queue_tail[sid];
  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign free_sid = SW'(free_idx);

  always_comb begin
    free_idx = 4'd0;
    free_found = 1'b0;
    for (int s = LIM - 1; s >= 0; s--) begin
      if (!slot_open[s]) begin
        free_idx = 4'(s);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    if (COUNT_WIDTH >= 16) ival_sat = COUNT_WIDTH'(cur.init_value);
    else if ((32'(cur.init_value) >> COUNT_WIDTH) != 0) ival_sat = CMAX;
    else ival_sat = COUNT_WIDTH'(cur.init_value);
  end

  logic out_free;
  assign out_free = empty || pop;

  always_ff @(posedge clk) begin
    if (cmd_take) cur <= cmd_in;
    if (rst) begin
      state <= S_IDLE;
      slot_open <= '0;
      queue_nonempty <= '0;
      empty <= 1'b1;
      walked <= '0;
    end else begin
      if (pop && !empty) empty <= 1'b1;
      case (state)
        S_IDLE: begin
          if (cmd_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            empty <= 1'b0;
            status <= ST_OK;
            sem_handle <= 4'd0;
            caller_blocked <= 1'b0;
            woken_valid <= 1'b0;
            woken_thread <= 5'd0;
            last <= 1'b1;
            state <= S_IDLE;
            if (cur.cmd == CMD_OPEN) begin
              if (free_found) begin
                slot_open[free_sid] <= 1'b1;
                queue_nonempty[free_sid] <= 1'b0;
                sem_count[free_sid] <= ival_sat;
                sem_handle <= free_idx;
              end else begin
                status <= ST_NO_SLOT;
              end
            end else if (!is_open) begin
              status <= ST_NOT_OPEN;
            end else begin
              case (cur.cmd)
                CMD_CLOSE: begin
                  if (queue_nonempty[sid]) begin
                    empty <= 1'b1;
                    walked <= '0;
                    state <= S_WALK;
                  end else begin
                    slot_open[sid] <= 1'b0;
                  end
                end
                CMD_WAIT: begin
                  if (sem_count[sid] != '0) begin
                    sem_count[sid] <= sem_count[sid] - 1'b1;
                  end else begin
                    if (queue_nonempty[sid]) begin
                      thread_next[queue_tail[sid]] <= cur.thread_id;
                    end else begin
                      queue_head[sid] <= cur.thread_id;
                      queue_nonempty[sid] <= 1'b1;
                    end
                    queue_tail[sid] <= cur.thread_id;
                    caller_blocked <= 1'b1;
                  end
                end
                default: begin
                  if (queue_nonempty[sid]) begin
                    woken_valid <= 1'b1;
                    woken_thread <= hd;
                    if (hd_is_tail) queue_nonempty[sid] <= 1'b0;
                    else queue_head[sid] <= thread_next[hd];
                  end else if (sem_count[sid] != CMAX) begin
                    sem_count[sid] <= sem_count[sid] + 1'b1;
                  end
                end
              endcase
            end
          end
        end
        S_WALK: begin
          if (out_free) begin
            empty <= 1'b0;
            status <= ST_OK;
            sem_handle <= 4'd0;
            caller_blocked <= 1'b0;
            woken_valid <= 1'b1;
            woken_thread <= hd;
            walked <= walked + 1'b1;
            if (hd_is_tail || 32'(walked) == CAP - 1) begin
              last <= 1'b1;
              slot_open[sid] <= 1'b0;
              queue_nonempty[sid] <= 1'b0;
              state <= S_IDLE;
            end else begin
              last <= 1'b0;
              queue_head[sid] <= thread_next[hd];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> state == S_IDLE) else $error("command taken while busy");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> 32'(walked) < CAP) else $error("close walk overran");
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && $past(state) == S_WALK) |-> state == S_WALK)
    else $error("walk left to a wrong state");
endmodule

/* rtl/counting_semaphore_unit.sv */
// Counting semaphore unit: a table of counting semaphores with FIFO wait queues.
// A command goes from the command queue into a command register, then updates
// the slot table once the result register is free; a close with waiters emits
// one woken thread per cycle when free. Results are held in one output register.
// Depends on csu_pkg, csu_front and csu_back.
module counting_semaphore_unit #(
  parameter int NUM_SEMS = csu_pkg::NumSemsDefault,
  parameter int NUM_THREADS = csu_pkg::NumThreadsDefault,
  parameter int COUNT_WIDTH = csu_pkg::CountWidthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [1:0] cmd,
  input  logic [3:0] sem_id,
  input  logic [4:0] thread_id,
  input  logic [15:0] init_value,
  output logic empty,
  input  logic pop,
  output logic [1:0] status,
  output logic [3:0] sem_handle,
  output logic caller_blocked,
  output logic woken_valid,
  output logic [4:0] woken_thread,
  output logic last
);
  import csu_pkg::*;

  cmd_t in_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_take;

  assign in_cmd = '{cmd: cmd, sem_id: sem_id, thread_id: thread_id, init_value: init_value};

  csu_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_cmd(in_cmd),
    .cmd_valid(q_valid), .cmd_take(q_take), .cmd_out(q_cmd)
  );

  csu_back #(.NUM_SEMS(NUM_SEMS), .NUM_THREADS(NUM_THREADS), .COUNT_WIDTH(COUNT_WIDTH))
  u_back (
    .clk(clk), .rst(rst), .cmd_valid(q_valid), .cmd_take(q_take), .cmd_in(q_cmd),
    .empty(empty), .pop(pop), .status(status), .sem_handle(sem_handle),
    .caller_blocked(caller_blocked), .woken_valid(woken_valid),
    .woken_thread(woken_thread), .last(last)
  );
endmodule

/* test/testbench.sv */
// Self-checking testbench for counting_semaphore_unit: open, close, wait and signal
// traffic against a behavioral semaphore table, with random idling on both sides.
// Depends on csu_pkg and the counting_semaphore_unit RTL.
`timescale 1ns / 100ps

module testbench;
  import csu_pkg::*;

  typedef struct {
    logic [1:0] status;
    logic [3:0] sem_handle;
    logic caller_blocked;
    logic woken_valid;
    logic [4:0] woken_thread;
    logic last;
  } sem_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [1:0] cmd = CMD_OPEN;
  logic [3:0] sem_id = '0;
  logic [4:0] thread_id = '0;
  logic [15:0] init_value = '0;
  logic [1:0] status;
  logic [3:0] sem_handle;
  logic caller_blocked, woken_valid, last;
  logic [4:0] woken_thread;

  bit slot_open[16];
  logic [15:0] sem_count[16];
  bit queue_nonempty[16];
  logic [4:0] queue_head[16];
  logic [4:0] queue_tail[16];
  logic [4:0] thread_next[32];

  sem_result_t expected_results[$];
  int errors = 0;
  int commands_sent = 0;
  int results_seen = 0;
  int blocked_seen = 0;
  int woken_seen = 0;
  int quiet_cycles = 0;
  bit idle_enable = 1'b1;
  bit pop_idle = 1'b0;

  counting_semaphore_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_result(logic [1:0] st, logic [3:0] h, logic b, logic wv,
                                     logic [4:0] wt, logic l);
    sem_result_t r;
    r.status = st;
    r.sem_handle = h;
    r.caller_blocked = b;
    r.woken_valid = wv;
    r.woken_thread = wt;
    r.last = l;
    expected_results.push_back(r);
  endfunction

  function automatic logic [4:0] dequeue_waiter(int s);
    logic [4:0] h;
    h = queue_head[s];
    if (h == queue_tail[s]) queue_nonempty[s] = 1'b0;
    else queue_head[s] = thread_next[h];
    return h;
  endfunction

  function automatic void predict_command(logic [1:0] c, logic [3:0] s, logic [4:0] t,
                                          logic [15:0] v);
    int k;
    if (c == CMD_OPEN) begin
      for (int i = 0; i < 16; i++) begin
        if (!slot_open[i]) begin
          slot_open[i] = 1'b1;
          sem_count[i] = v;
          queue_nonempty[i] = 1'b0;
          add_result(ST_OK, i[3:0], 0, 0, 0, 1);
          return;
        end
      end
      add_result(ST_NO_SLOT, 0, 0, 0, 0, 1);
      return;
    end
    if (!slot_open[s]) begin
      add_result(ST_NOT_OPEN, 0, 0, 0, 0, 1);
      return;
    end
    case (c)
      CMD_CLOSE: begin
        k = 0;
        while (queue_nonempty[s] && k < 32) begin
          add_result(ST_OK, 0, 0, 1, dequeue_waiter(s), 0);
          k++;
        end
        slot_open[s] = 1'b0;
        queue_nonempty[s] = 1'b0;
        if (k == 0) add_result(ST_OK, 0, 0, 0, 0, 1);
        else expected_results[$].last = 1'b1;
      end
      CMD_WAIT: begin
        if (sem_count[s] != 0) begin
          sem_count[s]--;
          add_result(ST_OK, 0, 0, 0, 0, 1);
        end else begin
          if (queue_nonempty[s]) thread_next[queue_tail[s]] = t;
          else begin
            queue_head[s] = t;
            queue_nonempty[s] = 1'b1;
          end
          queue_tail[s] = t;
          add_result(ST_OK, 0, 1, 0, 0, 1);
        end
      end
      default: begin
        if (queue_nonempty[s]) add_result(ST_OK, 0, 0, 1, dequeue_waiter(s), 1);
        else begin
          if (sem_count[s] != 16'hFFFF) sem_count[s]++;
          add_result(ST_OK, 0, 0, 0, 0, 1);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("Mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
             results_seen);
    errors++;
  endtask

  task automatic send_command(logic [1:0] c, logic [3:0] s, logic [4:0] t, logic [15:0] v);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    sem_id <= s;
    thread_id <= t;
    init_value <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_command(c, s, t, v);
    commands_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        sem_result_t r;
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("Unexpected transaction on the result side");
          errors++;
        end else begin
          r = expected_results.pop_front();
          if (status !== r.status) report_mismatch("status", int'(status), int'(r.status));
          if (sem_handle !== r.sem_handle)
            report_mismatch("sem_handle", int'(sem_handle), int'(r.sem_handle));
          if (caller_blocked !== r.caller_blocked)
            report_mismatch("caller_blocked", int'(caller_blocked), int'(r.caller_blocked));
          if (woken_valid !== r.woken_valid)
            report_mismatch("woken_valid", int'(woken_valid), int'(r.woken_valid));
          if (woken_thread !== r.woken_thread)
            report_mismatch("woken_thread", int'(woken_thread), int'(r.woken_thread));
          if (last !== r.last) report_mismatch("last", int'(last), int'(r.last));
          if (r.caller_blocked) blocked_seen++;
          if (r.woken_valid) woken_seen++;
        end
      end
      if (pop_idle) begin
        if ($urandom_range(0, 2) == 0) pop_idle = 1'b0;
      end else if (idle_enable && $urandom_range(0, 6) == 0) pop_idle = 1'b1;
      pop <= !pop_idle || !idle_enable;
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 5000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Open slots are tracked so that random traffic mostly targets live semaphores.
  function automatic logic [3:0] pick_slot();
    logic [3:0] s;
    for (int i = 0; i < 8; i++) begin
      s = 4'($urandom_range(0, 15));
      if (slot_open[s]) return s;
    end
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic test_directed();
    send_command(CMD_WAIT, 4'd15, 5'd31, 16'hFFFF);
    send_command(CMD_SIGNAL, 4'd0, 5'd0, 16'h0);
    send_command(CMD_CLOSE, 4'd3, 5'd0, 16'h0);
    send_command(CMD_OPEN, 4'd15, 5'd31, 16'hFFFF);
    send_command(CMD_SIGNAL, 4'd0, 5'd0, 16'h0);
    send_command(CMD_WAIT, 4'd0, 5'd1, 16'h0);
    send_command(CMD_OPEN, 4'd0, 5'd0, 16'h0);
    send_command(CMD_SIGNAL, 4'd1, 5'd0, 16'h0);
    send_command(CMD_WAIT, 4'd1, 5'd2, 16'h0);
    send_command(CMD_WAIT, 4'd1, 5'd10, 16'h0);
    send_command(CMD_WAIT, 4'd1, 5'd21, 16'h0);
    send_command(CMD_WAIT, 4'd1, 5'd31, 16'h0);
    send_command(CMD_SIGNAL, 4'd1, 5'd0, 16'h0);
    send_command(CMD_CLOSE, 4'd1, 5'd0, 16'h0);
    send_command(CMD_CLOSE, 4'd0, 5'd0, 16'h0);
    send_command(CMD_WAIT, 4'd0, 5'd0, 16'h0);
  endtask

  task automatic test_slot_exhaustion();
    for (int i = 0; i < 17; i++) send_command(CMD_OPEN, 4'd0, 5'd0, 16'($urandom));
    for (int i = 0; i < 16; i++) send_command(CMD_CLOSE, i[3:0], 5'd0, 16'd0);
  endtask

  task automatic test_random_traffic(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (i >= n - 30) idle_enable = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 10) send_command(CMD_OPEN, 4'($urandom), 5'($urandom),
                               16'($urandom_range(0, 3) == 0 ?
                                   $urandom : $urandom_range(0, 3)));
      else if (r < 16) send_command(CMD_CLOSE, pick_slot(), 5'($urandom), 16'($urandom));
      else if (r < 60) send_command(CMD_WAIT, pick_slot(), 5'($urandom), 16'($urandom));
      else send_command(CMD_SIGNAL, pick_slot(), 5'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_slot_exhaustion();
    test_random_traffic(120);
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d commands, checked %0d results (%0d blocked waits, %0d wakeups).",
             commands_sent, results_seen, blocked_seen, woken_seen);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

/* files.f */
rtl/csu_pkg.sv
rtl/csu_front.sv
rtl/csu_back.sv
rtl/counting_semaphore_unit.sv
test/testbench.sv
